>>> rtl/svam_pkg.sv
`default_nettype none
package svam_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;

    localparam int CFG_W            = 7;
    localparam int IDX_IN_W         = 6;
    localparam int IDX_OUT_W        = 6;
    localparam int PROJ_W           = 33;
    localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 7'd4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage
`default_nettype wire

>>> rtl/svam_cell.sv
`default_nettype none
module svam_cell #(
    parameter int W = 48
) (
    input  wire logic         i_clk,
    input  wire logic         i_load,
    input  wire logic [W-1:0] i_load_data,
    input  wire logic         i_shift,
    input  wire logic [W-1:0] i_next_data,
    output logic      [W-1:0] o_data
);

    logic [W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

>>> rtl/svam_dot.sv
`default_nettype none
module svam_dot #(
    parameter int COORD_BITS = svam_pkg::COORD_BITS_DEF,
    parameter int IDX_W      = 6,
    parameter int SUM_W      = 34
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [IDX_W-1:0]        i_index,
    input  wire logic [3*COORD_BITS-1:0] i_vertex,
    input  wire logic [3*COORD_BITS-1:0] i_dir,
    output logic                         o_valid,
    output logic      [IDX_W-1:0]        o_index,
    output logic signed [SUM_W-1:0]      o_sum
);

    localparam int CB = COORD_BITS;
    localparam int PW = 2 * COORD_BITS;

    logic signed [CB-1:0] vx, vy, vz, dx, dy, dz;
    logic signed [PW-1:0] r_px, r_py, r_pz;
    logic                 r_v1, r_v2;
    logic [IDX_W-1:0]     r_i1, r_i2;
    logic signed [SUM_W-1:0] r_sum;

    assign vx = i_vertex[CB-1:0];
    assign vy = i_vertex[2*CB-1:CB];
    assign vz = i_vertex[3*CB-1:2*CB];
    assign dx = i_dir[CB-1:0];
    assign dy = i_dir[2*CB-1:CB];
    assign dz = i_dir[3*CB-1:2*CB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // products, then sum of three
    always_ff @(posedge i_clk) begin
        r_px  <= vx * dx;
        r_py  <= vy * dy;
        r_pz  <= vz * dz;
        r_i1  <= i_index;
        r_sum <= SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz);
        r_i2  <= r_i1;
    end

    assign o_valid = r_v2;
    assign o_index = r_i2;
    assign o_sum   = r_sum;

endmodule
`default_nettype wire

>>> rtl/support_vertex_argmax.sv
`default_nettype none
// Support mapping over a stored vertex set. A beat with s_axis_tuser = 0 writes one vertex
// (signed fixed-point x, y, z) into slot vertex_index; slots at or above
// MAX_VERTICES are dropped. A beat with s_axis_tuser = 1 carries a direction and returns
// one result beat: the index of the vertex with the greatest dot product (lowest index on a
// tie) and that dot product in Q16.16, 33 bits. The vertices sit in a ring of register cells
// that turns one full revolution per query. The result beat is loaded once the ring has
// stopped and the multiply and add have drained, and the next beat can be taken once the
// result is loaded. When the effective vertex count equals MAX_VERTICES the last vertex
// is still in the two-stage multiply and add as the ring stops, so the drain waits for it.
// Otherwise the time does not depend on vertex_count; it is set by the ring length, the
// multiply and add and the result load. Input is held off while a query runs; a finished
// result waits in an output register, and a later query cannot finish while it waits.
// vertex_count is sampled when a query is taken: 0 acts as 1, values above MAX_VERTICES act
// as MAX_VERTICES.
module support_vertex_argmax #(
    parameter int MAX_VERTICES = svam_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = svam_pkg::COORD_BITS_DEF,
    localparam int IN_W  = ((svam_pkg::IDX_IN_W + 3 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((svam_pkg::IDX_OUT_W + svam_pkg::PROJ_W + 7) / 8) * 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [svam_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // vertex_index, coord_x, coord_y, coord_z
    input  wire logic [IN_W-1:0]            s_axis_tdata,
    // action
    input  wire logic                       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // farthest_index, best_projection
    output logic      [OUT_W-1:0]           m_axis_tdata
);

    localparam int CB     = COORD_BITS;
    localparam int VW     = 3 * COORD_BITS;
    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int CW     = (CNT_W > svam_pkg::CFG_W) ? CNT_W : svam_pkg::CFG_W;
    localparam int SW     = (IDX_W > svam_pkg::IDX_IN_W) ? IDX_W : svam_pkg::IDX_IN_W;
    localparam int SUM_W  = (2 * CB + 2 > 64) ? 64 : 2 * CB + 2;
    localparam int IW     = svam_pkg::IDX_IN_W;

    svam_pkg::t_state r_state, n_state;

    logic [svam_pkg::CFG_W-1:0] r_vertex_count;
    logic [CNT_W-1:0]           r_n, r_step;
    logic [CNT_W-1:0]           n_eff;
    logic [CW-1:0]              cnt_ext;
    logic [VW-1:0]              r_dir;
    logic [VW-1:0]              cell_data [MAX_VERTICES];
    logic [IW-1:0]              in_index;
    logic [VW-1:0]              in_coords;
    logic                       in_accept, shift, load_out, step_last;

    logic                       dot_valid;
    logic [IDX_W-1:0]           dot_index;
    logic signed [SUM_W-1:0]    dot_sum;
    logic signed [SUM_W-1:0]    r_best;
    logic [IDX_W-1:0]           r_best_idx;

    logic                       r_out_valid;
    logic [OUT_W-1:0]           r_out_data;

    // stage one of the dot unit is busy in the cycle after the ring stops
    logic                       r_tail;

    assign in_index  = s_axis_tdata[IW-1:0];
    assign in_coords = s_axis_tdata[IW+VW-1:IW];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign shift     = (r_state == svam_pkg::ST_RUN);
    assign step_last = (r_step == CNT_W'(MAX_VERTICES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= svam_pkg::VERTEX_COUNT_RST;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    always_comb begin
        cnt_ext = CW'(r_vertex_count);
        if (cnt_ext == '0) begin
            n_eff = CNT_W'(1);
        end else if (cnt_ext > CW'(MAX_VERTICES)) begin
            n_eff = CNT_W'(MAX_VERTICES);
        end else begin
            n_eff = CNT_W'(cnt_ext);
        end
    end

    // vertex ring: cell 0 faces the dot unit
    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        logic sel;
        assign sel = in_accept && (s_axis_tuser == svam_pkg::ACT_WRITE)
                     && (SW'(in_index) == SW'(g));
        svam_cell #(
            .W (VW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_load      (sel),
            .i_load_data (in_coords),
            .i_shift     (shift),
            .i_next_data (cell_data[(g + 1) % MAX_VERTICES]),
            .o_data      (cell_data[g])
        );
    end

    svam_dot #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W),
        .SUM_W      (SUM_W)
    ) u_dot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (shift && (r_step < r_n)),
        .i_index  (r_step[IDX_W-1:0]),
        .i_vertex (cell_data[0]),
        .i_dir    (r_dir),
        .o_valid  (dot_valid),
        .o_index  (dot_index),
        .o_sum    (dot_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svam_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            svam_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (s_axis_tuser == svam_pkg::ACT_QUERY)) begin
                    n_state = svam_pkg::ST_RUN;
                end
            end
            svam_pkg::ST_RUN: begin
                if (step_last) begin
                    n_state = svam_pkg::ST_DRAIN;
                end
            end
            svam_pkg::ST_DRAIN: begin
                if (!dot_valid && !r_tail && (!r_out_valid || m_axis_tready)) begin
                    load_out = 1'b1;
                    n_state  = svam_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = svam_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= 1'b0;
        end else begin
            r_tail <= shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && (s_axis_tuser == svam_pkg::ACT_QUERY)) begin
            r_dir <= in_coords;
            r_n   <= n_eff;
        end
        if (shift) begin
            r_step <= r_step + CNT_W'(1);
        end else begin
            r_step <= '0;
        end
        if (dot_valid && ((dot_index == '0) || (dot_sum > r_best))) begin
            r_best     <= dot_sum;
            r_best_idx <= dot_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= OUT_W'({svam_pkg::PROJ_W'(r_best),
                                  svam_pkg::IDX_OUT_W'(r_best_idx)});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire
